// File: hdl/pce_pkg.sv
// Shared types, constants and bit-manipulation functions for the programmable CRC engine.
package pce_pkg;

    localparam int CRC_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int NUM_COLS  = 32;
    localparam int COL_IDX_W = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [COL_IDX_W-1:0] LAST_COL   = 5'd31;
    localparam logic [CRC_W-1:0]     POLY_RESET = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0]     INIT_RESET = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_IS_8   = 3'd0,
        REG_POLY_COEFF  = 3'd1,
        REG_INIT_VALUE  = 3'd2,
        REG_REFLECT_IN  = 3'd3,
        REG_SHIFT_RIGHT = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic             size_is_8;
        logic [CRC_W-1:0] poly_coeff;
        logic [CRC_W-1:0] init_value;
        logic             reflect_in;
        logic             shift_right;
    } cfg_t;

    typedef struct packed {
        logic                 busy;
        logic [COL_IDX_W-1:0] col;
    } sweep_t;

    // Column i holds the remainder of x^(width+i); the fold XORs the columns
    // selected by the bits of (crc ^ data).
    typedef logic [NUM_COLS-1:0][CRC_W-1:0] matrix_t;

    function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++)
        begin
            r[i] = b[BYTE_W-1-i];
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] rev32(input logic [CRC_W-1:0] w);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++)
        begin
            r[i] = w[CRC_W-1-i];
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] rev_bytes(input logic [CRC_W-1:0] w);
        logic [CRC_W-1:0] r;
        for (int k = 0; k < CRC_W / BYTE_W; k++)
        begin
            r[k*BYTE_W +: BYTE_W] = rev8(w[k*BYTE_W +: BYTE_W]);
        end
        return r;
    endfunction

    // One MSB-first shift of the LFSR, 8 or 32 bits wide.
    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] t,
                                                  input logic [CRC_W-1:0] p,
                                                  input logic             size8);
        logic [CRC_W-1:0] r;
        if (size8)
        begin
            r = {{(CRC_W-BYTE_W){1'b0}}, t[BYTE_W-2:0], 1'b0}
                ^ (t[BYTE_W-1] ? p : '0);
        end
        else
        begin
            r = {t[CRC_W-2:0], 1'b0} ^ (t[CRC_W-1] ? p : '0);
        end
        return r;
    endfunction

endpackage

// File: hdl/pce_regs.sv
// Configuration register file and write port of the CRC engine.
module pce_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pce_pkg::CRC_W-1:0]      cfg_data,
    output pce_pkg::cfg_t                  cfg,
    output logic                           rebuild
);

    pce_pkg::cfg_t cfg_reg;
    pce_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        rebuild  = 1'b0;
        if (wr_en)
        begin
            unique case (pce_pkg::reg_index_t'(cfg_index))
                pce_pkg::REG_SIZE_IS_8:
                begin
                    cfg_next.size_is_8 = cfg_data[0];
                    rebuild            = 1'b1;
                end
                pce_pkg::REG_POLY_COEFF:
                begin
                    cfg_next.poly_coeff = cfg_data;
                    rebuild             = 1'b1;
                end
                pce_pkg::REG_INIT_VALUE:  cfg_next.init_value = cfg_data;
                pce_pkg::REG_REFLECT_IN:  cfg_next.reflect_in = cfg_data[0];
                pce_pkg::REG_SHIFT_RIGHT:
                begin
                    cfg_next.shift_right = cfg_data[0];
                    rebuild              = 1'b1;
                end
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_is_8   <= 1'b0;
            cfg_reg.poly_coeff  <= pce_pkg::POLY_RESET;
            cfg_reg.init_value  <= pce_pkg::INIT_RESET;
            cfg_reg.reflect_in  <= 1'b0;
            cfg_reg.shift_right <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hdl/pce_matrix.sv
// Builds the fold matrix from the active polynomial, one column per cycle.
module pce_matrix (
    input  logic                clk,
    input  logic                rst_n,
    input  pce_pkg::cfg_t       cfg,
    input  logic                rebuild,
    output pce_pkg::matrix_t    matrix,
    output pce_pkg::sweep_t     status
);

    logic                                busy_reg;
    logic                                busy_next;
    logic [pce_pkg::COL_IDX_W-1:0]       col_reg;
    logic [pce_pkg::COL_IDX_W-1:0]       col_next;
    logic [pce_pkg::CRC_W-1:0]           term_reg;
    logic [pce_pkg::CRC_W-1:0]           term_cur;
    logic [pce_pkg::CRC_W-1:0]           poly_eff;
    logic                                size8_eff;
    pce_pkg::matrix_t                    matrix_reg;

    assign size8_eff = cfg.size_is_8;

    always_comb
    begin
        priority if (cfg.size_is_8)
            poly_eff = {{(pce_pkg::CRC_W-pce_pkg::BYTE_W){1'b0}},
                        cfg.poly_coeff[pce_pkg::BYTE_W-1:0]};
        else if (cfg.shift_right)
            poly_eff = pce_pkg::rev32(cfg.poly_coeff);
        else
            poly_eff = cfg.poly_coeff;
    end

    // First column is the polynomial itself; each next one is one more shift.
    assign term_cur = (col_reg == '0) ? poly_eff : term_reg;

    always_comb
    begin
        busy_next = busy_reg;
        col_next  = col_reg;
        if (rebuild)
        begin
            busy_next = 1'b1;
            col_next  = '0;
        end
        else if (busy_reg)
        begin
            col_next = col_reg + 1'b1;
            if (col_reg == pce_pkg::LAST_COL)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            col_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            col_reg  <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !rebuild)
        begin
            matrix_reg[col_reg] <= term_cur;
            term_reg            <= pce_pkg::crc_step(term_cur, poly_eff, size8_eff);
        end
    end

    assign matrix      = matrix_reg;
    assign status.busy = busy_reg;
    assign status.col  = col_reg;

endmodule

// File: hdl/pce_fold.sv
// Input register, combinational CRC fold and result register.
module pce_fold (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pce_pkg::cfg_t                cfg,
    input  pce_pkg::matrix_t             matrix,
    input  logic                         hold,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic [pce_pkg::CRC_W-1:0]    data,
    input  logic                         last,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [pce_pkg::CRC_W-1:0]    crc_value
);

    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic [pce_pkg::CRC_W-1:0]    s1_data_reg;
    logic                         s1_last_reg;
    logic                         s1_adv;
    logic                         accept;

    logic [pce_pkg::CRC_W-1:0]    crc_reg;
    logic                         in_msg_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [pce_pkg::CRC_W-1:0]    out_crc_reg;

    logic [pce_pkg::CRC_W-1:0]    base;
    logic [pce_pkg::BYTE_W-1:0]   byte_in;
    logic [pce_pkg::CRC_W-1:0]    word_in;
    logic [pce_pkg::CRC_W-1:0]    vec;
    logic [pce_pkg::CRC_W-1:0]    crc_next;
    logic [pce_pkg::CRC_W-1:0]    result;

    // Advance the held item unless it carries a result and the output holds one not being taken.
    assign s1_adv     = s1_valid_reg
                        && (!s1_last_reg || !out_valid_reg || result_ready);
    assign item_ready = !hold && (!s1_valid_reg || s1_adv);
    assign accept     = item_valid && item_ready;

    assign base = in_msg_reg ? crc_reg : cfg.init_value;

    always_comb
    begin
        byte_in = cfg.reflect_in ? pce_pkg::rev8(s1_data_reg[pce_pkg::BYTE_W-1:0])
                                 : s1_data_reg[pce_pkg::BYTE_W-1:0];
        word_in = (cfg.shift_right ^ cfg.reflect_in) ? pce_pkg::rev_bytes(s1_data_reg)
                                                     : s1_data_reg;
        if (cfg.size_is_8)
            vec = {{(pce_pkg::CRC_W-pce_pkg::BYTE_W){1'b0}},
                   base[pce_pkg::BYTE_W-1:0] ^ byte_in};
        else
            vec = base ^ word_in;
    end

    always_comb
    begin
        crc_next = '0;
        for (int i = 0; i < pce_pkg::NUM_COLS; i++)
        begin
            crc_next = crc_next ^ (vec[i] ? matrix[i] : '0);
        end
        result = (!cfg.size_is_8 && cfg.shift_right) ? pce_pkg::rev32(crc_next)
                                                     : crc_next;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv && s1_last_reg)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            in_msg_reg    <= 1'b0;
            crc_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                in_msg_reg <= !s1_last_reg;
                crc_reg    <= crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= data;
            s1_last_reg <= last;
        end
        if (s1_adv && s1_last_reg)
        begin
            out_crc_reg <= result;
        end
    end

    assign result_valid = out_valid_reg;
    assign crc_value    = out_crc_reg;

endmodule

// File: hdl/programmable_crc_engine_core.sv
// Top level of the programmable CRC engine: config registers, fold matrix and datapath.
//
// The engine takes one item per clock cycle on the item channel unless the matrix is being
// built or a waiting CRC result is not being taken. Each item waits in an input register and
// is folded into the running CRC through a precomputed 32-column XOR matrix; the CRC of the
// item flagged last is stored in the result register and raised on the result channel.
// The matrix is built one column per cycle from the active polynomial, so after reset and
// after every write to size_is_8, poly_coeff or shift_right item_ready stays low until the
// build ends; init_value and reflect_in need no rebuild. The config port never stalls.
module programmable_crc_engine_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pce_pkg::CRC_W-1:0]     cfg_data,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [pce_pkg::CRC_W-1:0]     data,
    input  logic                          last,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [pce_pkg::CRC_W-1:0]     crc_value
);

    pce_pkg::cfg_t    cfg;
    logic             rebuild;
    pce_pkg::matrix_t matrix;
    pce_pkg::sweep_t  status;

    pce_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .rebuild   (rebuild)
    );

    pce_matrix u_matrix (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .rebuild (rebuild),
        .matrix  (matrix),
        .status  (status)
    );

    pce_fold u_fold (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .matrix       (matrix),
        .hold         (status.busy),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .data         (data),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .crc_value    (crc_value)
    );

`ifndef SYNTHESIS
    a_no_accept_while_building: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !item_ready)
        else $error("item accepted while fold matrix is being built");

    a_poly_write_restarts_build: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_index == pce_pkg::REG_POLY_COEFF))
        |=> (status.busy && (status.col == '0)))
        else $error("polynomial write did not restart matrix build");

    a_build_runs_full_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(status.busy) |-> ($past(status.col) == pce_pkg::LAST_COL))
        else $error("matrix build ended before the last column");
`endif

endmodule
